// ===== rtl/tpmspi_pkg.sv =====
// tpm spi framer package: constants, phase codes, item, result and state types, header helpers
// no dependencies; compiled first
`default_nettype none

package tpmspi_pkg;

  localparam int FRAME_MAX   = 64;
  localparam int RETRY_LIMIT = 50;

  localparam int FRAME_W = $clog2(FRAME_MAX + 1);
  localparam int POLL_W  = $clog2(RETRY_LIMIT + 1);

  // header constants
  localparam logic [7:0] READ_FLAG  = 8'h80;
  localparam logic [7:0] HDR_MARKER = 8'hd4;
  localparam logic [7:0] IDLE_BYTE  = 8'h00;

  // request actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_XCHG  = 2'd1;
  localparam logic [1:0] ACT_WDATA = 2'd2;

  // phase codes
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_HEADER     = 3'd1;
  localparam logic [2:0] PH_POLL       = 3'd2;
  localparam logic [2:0] PH_READ       = 3'd3;
  localparam logic [2:0] PH_WAIT_WRITE = 3'd4;
  localparam logic [2:0] PH_WRITE_SLOT = 3'd5;

  // header slot indexes
  localparam logic [1:0] HDR_LEN   = 2'd0;
  localparam logic [1:0] HDR_MARK  = 2'd1;
  localparam logic [1:0] HDR_ADDRH = 2'd2;
  localparam logic [1:0] HDR_ADDRL = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [15:0] length;
    logic        is_read;
    logic [7:0]  miso_byte;
    logic [7:0]  write_byte;
  } item_t;

  typedef struct packed {
    logic        mosi_valid;
    logic [7:0]  mosi_byte;
    logic        release_select;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        need_write;
    logic        done_res;
    logic        status;
  } result_t;

  typedef struct packed {
    logic [2:0]         phase;
    logic [15:0]        reg_address;
    logic [15:0]        bytes_remaining;
    logic [FRAME_W-1:0] frame_bytes_left;
    logic [1:0]         header_index;
    logic [POLL_W-1:0]  poll_count;
    logic               reading;
  } state_t;

  // bytes in the next frame
  function automatic logic [FRAME_W-1:0] frame_len(input logic [15:0] remaining);
    if (remaining < 16'(FRAME_MAX)) begin
      return remaining[FRAME_W-1:0];
    end
    return FRAME_W'(FRAME_MAX);
  endfunction

  function automatic logic [7:0] header_byte(input logic [1:0] idx, input logic reading,
                                             input logic [FRAME_W-1:0] fbl,
                                             input logic [15:0] addr);
    logic [FRAME_W-1:0] len_m1;
    len_m1 = fbl - FRAME_W'(1);
    case (idx)
      HDR_LEN:   return (reading ? READ_FLAG : 8'h00) | {1'b0, 7'(len_m1)};
      HDR_MARK:  return HDR_MARKER;
      HDR_ADDRH: return addr[15:8];
      default:   return addr[7:0];
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tpmspi_req_if.sv =====
// request channel interface: valid/ready handshake with the framer request fields
// depends on nothing
`default_nettype none

interface tpmspi_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] address;
  logic [15:0] length;
  logic        is_read;
  logic [7:0]  miso_byte;
  logic [7:0]  write_byte;

  modport source (output valid, action, address, length, is_read, miso_byte, write_byte,
                  input ready);
  modport sink   (input valid, action, address, length, is_read, miso_byte, write_byte,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/tpmspi_res_if.sv =====
// result channel interface: valid/ready handshake with the framer result fields
// depends on nothing
`default_nettype none

interface tpmspi_res_if;
  logic       valid;
  logic       ready;
  logic       mosi_valid;
  logic [7:0] mosi_byte;
  logic       release_select;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       need_write;
  logic       done_res;
  logic       status;

  modport source (output valid, mosi_valid, mosi_byte, release_select, read_valid, read_byte,
                  need_write, done_res, status, input ready);
  modport sink   (input valid, mosi_valid, mosi_byte, release_select, read_valid, read_byte,
                  need_write, done_res, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/tpmspi_step.sv =====
// framer next-state logic: one request against the current state gives next state and result
// depends on tpmspi_pkg
`default_nettype none

module tpmspi_step (
  input  tpmspi_pkg::state_t  cur,
  input  tpmspi_pkg::item_t   item,
  output tpmspi_pkg::state_t  nxt,
  output tpmspi_pkg::result_t res
);
  import tpmspi_pkg::*;

  always_comb begin
    logic              go_frame;
    logic              go_payload;
    logic [POLL_W-1:0] poll_inc;

    nxt        = cur;
    res        = '0;
    go_frame   = 1'b0;
    go_payload = 1'b0;
    poll_inc   = cur.poll_count + POLL_W'(1);

    case (item.action)
      ACT_START: begin
        if (cur.phase == PH_IDLE) begin
          nxt.reg_address     = item.address;
          nxt.bytes_remaining = item.length;
          nxt.reading         = item.is_read;
          nxt.poll_count      = '0;
          if (item.length == 16'd0) begin
            res.done_res = 1'b1;
          end else begin
            go_frame = 1'b1;
          end
        end
      end
      ACT_XCHG: begin
        case (cur.phase)
          PH_HEADER: begin
            if (cur.header_index != HDR_ADDRL) begin
              nxt.header_index = cur.header_index + 2'd1;
              res.mosi_valid   = 1'b1;
              res.mosi_byte    = header_byte(nxt.header_index, cur.reading,
                                             cur.frame_bytes_left, cur.reg_address);
            end else if (item.miso_byte[0]) begin
              go_payload = 1'b1;
            end else begin
              nxt.phase      = PH_POLL;
              nxt.poll_count = '0;
              res.mosi_valid = 1'b1;
              res.mosi_byte  = IDLE_BYTE;
            end
          end
          PH_POLL: begin
            nxt.poll_count = poll_inc;
            if (item.miso_byte[0]) begin
              go_payload = 1'b1;
            end else if (poll_inc >= POLL_W'(RETRY_LIMIT)) begin
              // wait-state timeout: drop select and finish with error
              nxt.phase          = PH_IDLE;
              res.release_select = 1'b1;
              res.done_res       = 1'b1;
              res.status         = 1'b1;
            end else begin
              res.mosi_valid = 1'b1;
              res.mosi_byte  = IDLE_BYTE;
            end
          end
          PH_READ, PH_WRITE_SLOT: begin
            if (cur.phase == PH_READ) begin
              res.read_valid = 1'b1;
              res.read_byte  = item.miso_byte;
            end
            nxt.frame_bytes_left = cur.frame_bytes_left - FRAME_W'(1);
            nxt.bytes_remaining  = cur.bytes_remaining - 16'd1;
            if (nxt.frame_bytes_left != '0) begin
              go_payload = 1'b1;
            end else if (nxt.bytes_remaining != 16'd0) begin
              go_frame = 1'b1;
            end else begin
              nxt.phase    = PH_IDLE;
              res.done_res = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      ACT_WDATA: begin
        if (cur.phase == PH_WAIT_WRITE) begin
          nxt.phase          = PH_WRITE_SLOT;
          res.mosi_valid     = 1'b1;
          res.mosi_byte      = item.write_byte;
          res.release_select = (cur.frame_bytes_left == FRAME_W'(1));
        end
      end
      default: begin
      end
    endcase

    // open a new frame with its length byte
    if (go_frame) begin
      nxt.frame_bytes_left = frame_len(nxt.bytes_remaining);
      nxt.header_index     = HDR_LEN;
      nxt.phase            = PH_HEADER;
      res.mosi_valid       = 1'b1;
      res.mosi_byte        = header_byte(HDR_LEN, nxt.reading, nxt.frame_bytes_left,
                                         nxt.reg_address);
    end

    // next payload slot
    if (go_payload) begin
      if (nxt.reading) begin
        nxt.phase          = PH_READ;
        res.mosi_valid     = 1'b1;
        res.mosi_byte      = IDLE_BYTE;
        res.release_select = (nxt.frame_bytes_left == FRAME_W'(1));
      end else begin
        nxt.phase      = PH_WAIT_WRITE;
        res.need_write = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tpm_spi_transaction_framer.sv =====
// top level of the tpm spi transaction framer: state register, step logic, result register
// depends on tpmspi_pkg, tpmspi_req_if, tpmspi_res_if, tpmspi_step
`default_nettype none

// channel | dir | handshake   | carries
// req     | in  | valid/ready | action, address, length, is_read, miso_byte, write_byte
// res     | out | valid/ready | mosi_valid, mosi_byte, release_select, read_valid,
//         |     |             | read_byte, need_write, done_res, status
//
// every request gives exactly one result, held in the result register from the cycle after it is taken
// a request is taken in any cycle where the result register is empty or being emptied,
// so back-to-back requests run at one per cycle; the result register is the only stage
// a stalled result holds in its register and stops further requests until it leaves
// rst (synchronous) returns the framer to idle with all counts cleared and no result held

module tpm_spi_transaction_framer (
  input  wire logic     clk,
  input  wire logic     rst,
  tpmspi_req_if.sink    req,
  tpmspi_res_if.source  res
);
  import tpmspi_pkg::*;

  state_t  state;
  state_t  state_next;
  item_t   item;
  result_t result;
  result_t result_next;
  logic    res_valid;
  logic    take;

  // a request may enter while the held result is leaving
  assign req.ready = !res_valid || res.ready;
  assign take      = req.valid && req.ready;

  assign item.action     = req.action;
  assign item.address    = req.address;
  assign item.length     = req.length;
  assign item.is_read    = req.is_read;
  assign item.miso_byte  = req.miso_byte;
  assign item.write_byte = req.write_byte;

  // framing decisions: header slots, polling, payload and frame boundaries
  tpmspi_step u_step (
    .cur  (state),
    .item (item),
    .nxt  (state_next),
    .res  (result_next)
  );

  // framer state advances only on a taken request
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (take) begin
      state <= state_next;
    end
  end

  // result register with its valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  assign res.valid          = res_valid;
  assign res.mosi_valid     = result.mosi_valid;
  assign res.mosi_byte      = result.mosi_byte;
  assign res.release_select = result.release_select;
  assign res.read_valid     = result.read_valid;
  assign res.read_byte      = result.read_byte;
  assign res.need_write     = result.need_write;
  assign res.done_res       = result.done_res;
  assign res.status         = result.status;

endmodule

`default_nettype wire

// ===== tb/tpmspi_checker.sv =====
`timescale 1ns / 100ps
// framer checker: watches both channels, predicts each result and compares it
// depends on tpmspi_pkg, tpmspi_req_if and tpmspi_res_if

module tpmspi_checker (
  input  logic   clk,
  input  logic   rst,
  tpmspi_req_if  req,
  tpmspi_res_if  res,
  output int     mismatches,
  output int     outstanding
);
  import tpmspi_pkg::*;

  // predicted framer state
  logic [2:0]         fr_phase;
  logic [15:0]        fr_addr;
  logic [15:0]        fr_remaining;
  logic [FRAME_W-1:0] frame_left;
  logic [1:0]         hdr_idx;
  logic [POLL_W-1:0]  poll_cnt;
  logic               fr_reading;

  result_t expected_results[$];
  int      failures;

  function automatic logic [7:0] header_out(input logic [1:0] idx);
    case (idx)
      HDR_LEN:   return (fr_reading ? READ_FLAG : 8'h00) | {1'b0, 7'(frame_left - 1'b1)};
      HDR_MARK:  return HDR_MARKER;
      HDR_ADDRH: return fr_addr[15:8];
      default:   return fr_addr[7:0];
    endcase
  endfunction

  function automatic void open_frame(inout result_t r);
    frame_left = (fr_remaining < 16'(FRAME_MAX)) ? FRAME_W'(fr_remaining) : FRAME_W'(FRAME_MAX);
    hdr_idx = HDR_LEN;
    fr_phase = PH_HEADER;
    r.mosi_valid = 1'b1;
    r.mosi_byte = header_out(HDR_LEN);
  endfunction

  function automatic void open_payload(inout result_t r);
    if (fr_reading) begin
      fr_phase = PH_READ;
      r.mosi_valid = 1'b1;
      r.mosi_byte = IDLE_BYTE;
      r.release_select = (frame_left == FRAME_W'(1));
    end else begin
      fr_phase = PH_WAIT_WRITE;
      r.need_write = 1'b1;
    end
  endfunction

  // one payload byte has gone: next byte, next frame or the end
  function automatic void payload_advance(inout result_t r);
    frame_left = frame_left - 1'b1;
    fr_remaining = fr_remaining - 1'b1;
    if (frame_left != '0) begin
      open_payload(r);
    end else if (fr_remaining != '0) begin
      open_frame(r);
    end else begin
      fr_phase = PH_IDLE;
      r.done_res = 1'b1;
    end
  endfunction

  function automatic result_t predict_framer(input item_t it);
    result_t r;
    r = '0;
    case (it.action)
      ACT_START: begin
        if (fr_phase == PH_IDLE) begin
          fr_addr = it.address;
          fr_remaining = it.length;
          fr_reading = it.is_read;
          poll_cnt = '0;
          if (it.length == '0) begin
            r.done_res = 1'b1;
          end else begin
            open_frame(r);
          end
        end
      end
      ACT_XCHG: begin
        case (fr_phase)
          PH_HEADER: begin
            if (hdr_idx != HDR_ADDRL) begin
              hdr_idx = hdr_idx + 1'b1;
              r.mosi_valid = 1'b1;
              r.mosi_byte = header_out(hdr_idx);
            end else if (it.miso_byte[0]) begin
              open_payload(r);
            end else begin
              fr_phase = PH_POLL;
              poll_cnt = '0;
              r.mosi_valid = 1'b1;
              r.mosi_byte = IDLE_BYTE;
            end
          end
          PH_POLL: begin
            poll_cnt = poll_cnt + 1'b1;
            if (it.miso_byte[0]) begin
              open_payload(r);
            end else if (poll_cnt >= POLL_W'(RETRY_LIMIT)) begin
              fr_phase = PH_IDLE;
              r.release_select = 1'b1;
              r.done_res = 1'b1;
              r.status = 1'b1;
            end else begin
              r.mosi_valid = 1'b1;
              r.mosi_byte = IDLE_BYTE;
            end
          end
          PH_READ: begin
            r.read_valid = 1'b1;
            r.read_byte = it.miso_byte;
            payload_advance(r);
          end
          PH_WRITE_SLOT: begin
            payload_advance(r);
          end
          default: begin
          end
        endcase
      end
      ACT_WDATA: begin
        if (fr_phase == PH_WAIT_WRITE) begin
          fr_phase = PH_WRITE_SLOT;
          r.mosi_valid = 1'b1;
          r.mosi_byte = it.write_byte;
          r.release_select = (frame_left == FRAME_W'(1));
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("mosi %0b/%02h rel %0b rd %0b/%02h need_wr %0b done %0b status %0b",
                     r.mosi_valid, r.mosi_byte, r.release_select, r.read_valid, r.read_byte,
                     r.need_write, r.done_res, r.status);
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    item_t   taken;
    if (rst) begin
      fr_phase = PH_IDLE;
      fr_addr = '0;
      fr_remaining = '0;
      frame_left = '0;
      hdr_idx = HDR_LEN;
      poll_cnt = '0;
      fr_reading = 1'b0;
      expected_results.delete();
      failures = 0;
    end else begin
      // result first: it belongs to an earlier request, never to one taken now
      if (res.valid && res.ready) begin
        got = {res.mosi_valid, res.mosi_byte, res.release_select, res.read_valid,
               res.read_byte, res.need_write, res.done_res, res.status};
        if (expected_results.size() == 0) begin
          if (failures < 10) begin
            $display("%0t: result with nothing pending: %s", $time, show(got));
          end
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            if (failures < 10) begin
              $display("%0t: expected %s", $time, show(want));
              $display("%0t: actual   %s", $time, show(got));
            end
            failures++;
          end
        end
      end
      if (req.valid && req.ready) begin
        taken = {req.action, req.address, req.length, req.is_read, req.miso_byte,
                 req.write_byte};
        expected_results.push_back(predict_framer(taken));
      end
    end
    mismatches <= failures;
    outstanding <= expected_results.size();
  end

endmodule

// ===== tb/tpm_spi_transaction_framer_test.sv =====
`timescale 1ns / 100ps
// testbench top for the tpm spi framer: clock, reset, request stimulus, result stalls
// depends on tpmspi_pkg, both channel interfaces, the framer and tpmspi_checker

module tpm_spi_transaction_framer_test;
  import tpmspi_pkg::*;

  // action value with no meaning to the framer
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // where an ignored request is slipped in
  typedef enum {SPOT_IDLE, SPOT_BUSY, SPOT_WAIT_WRITE} spot_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tpmspi_req_if req();
  tpmspi_res_if res();

  int mismatches;
  int outstanding;

  // idling knobs, in percent per cycle
  int idle_pct = 0;
  int stall_pct = 0;
  int idle_plan[4] = '{0, 56, 0, 22};
  int stall_plan[4] = '{0, 0, 56, 22};

  // requests that move the transfer along; ignored ones are not counted
  int item_count = 0;

  always #5 clk = ~clk;

  tpm_spi_transaction_framer dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

  tpmspi_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .res         (res),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // request with every field random, then the action forced
  function automatic item_t item_of(input logic [1:0] act);
    item_t it;
    it.action = act;
    it.address = 16'($urandom);
    it.length = 16'($urandom);
    it.is_read = 1'($urandom);
    it.miso_byte = 8'($urandom);
    it.write_byte = 8'($urandom);
    return it;
  endfunction

  // random idle cycles, then hold the request until the framer takes it
  task automatic send_request(input item_t it, input bit counted);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.action <= it.action;
    req.address <= it.address;
    req.length <= it.length;
    req.is_read <= it.is_read;
    req.miso_byte <= it.miso_byte;
    req.write_byte <= it.write_byte;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (counted) item_count++;
  endtask

  // a request the framer must ignore in the given situation
  task automatic send_noise(input spot_t spot);
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(2);
    case (spot)
      SPOT_IDLE:
        it = item_of(pick == 0 ? ACT_UNUSED : (pick == 1 ? ACT_XCHG : ACT_WDATA));
      SPOT_BUSY:
        it = item_of(pick == 0 ? ACT_UNUSED : (pick == 1 ? ACT_START : ACT_WDATA));
      default:
        it = item_of(pick == 0 ? ACT_UNUSED : (pick == 1 ? ACT_START : ACT_XCHG));
    endcase
    send_request(it, 1'b0);
  endtask

  // one step inside a transfer, sometimes preceded by a request that must be ignored
  task automatic step_action(input logic [1:0] act, input logic [7:0] miso,
                             input logic [7:0] wbyte);
    item_t it;
    if ($urandom_range(99) < 4) begin
      send_noise(act == ACT_WDATA ? SPOT_WAIT_WRITE : SPOT_BUSY);
    end
    it = item_of(act);
    it.miso_byte = miso;
    it.write_byte = wbyte;
    send_request(it, 1'b1);
  endtask

  // a well-formed transfer; polls < 0 means the device is ready at once,
  // polls >= RETRY_LIMIT runs the wait state out into a timeout
  task automatic run_transfer(input logic [15:0] addr, input logic [15:0] len, input bit rd,
                              input int polls);
    item_t it;
    int    rem;
    int    n;
    if ($urandom_range(99) < 5) send_noise(SPOT_IDLE);
    it = item_of(ACT_START);
    it.address = addr;
    it.length = len;
    it.is_read = rd;
    send_request(it, 1'b1);
    rem = len;
    while (rem > 0) begin
      n = (rem < FRAME_MAX) ? rem : FRAME_MAX;
      // three header slots after the one the start put out
      repeat (3) step_action(ACT_XCHG, 8'($urandom), 8'($urandom));
      if (polls < 0) begin
        step_action(ACT_XCHG, 8'($urandom) | 8'h01, 8'($urandom));
      end else begin
        step_action(ACT_XCHG, 8'($urandom) & 8'hfe, 8'($urandom));
        repeat ((polls < RETRY_LIMIT) ? polls : RETRY_LIMIT) begin
          step_action(ACT_XCHG, 8'($urandom) & 8'hfe, 8'($urandom));
        end
        if (polls >= RETRY_LIMIT) return;
        step_action(ACT_XCHG, 8'($urandom) | 8'h01, 8'($urandom));
      end
      repeat (n) begin
        if (!rd) step_action(ACT_WDATA, 8'($urandom), 8'($urandom));
        step_action(ACT_XCHG, 8'($urandom), 8'($urandom));
      end
      rem -= n;
    end
  endtask

  // the sender holds off until every result has come back
  task automatic pause_until_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver: stalls at the rate of the current phase
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    item_t       it;
    int          ph;
    int          base;
    int unsigned pick;
    logic [15:0] len;
    int          polls;

    req.valid <= 1'b0;
    req.action <= ACT_START;
    req.address <= '0;
    req.length <= '0;
    req.is_read <= 1'b0;
    req.miso_byte <= '0;
    req.write_byte <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, no idling
    // exchange, write data and the unused action are all ignored while idle
    send_request(item_of(ACT_XCHG), 1'b0);
    send_request(item_of(ACT_WDATA), 1'b0);
    send_request(item_of(ACT_UNUSED), 1'b0);
    // zero length answers done straight away
    run_transfer(16'hffff, 16'h0000, 1'b1, -1);
    // single read byte, lowest address
    run_transfer(16'h0000, 16'h0001, 1'b1, -1);
    // two-byte write at the top address with one wait state
    it = item_of(ACT_START);
    it.address = 16'hffff;
    it.length = 16'h0002;
    it.is_read = 1'b0;
    send_request(it, 1'b1);
    repeat (3) step_action(ACT_XCHG, 8'hff, 8'h00);
    // start while busy is dropped
    send_request(item_of(ACT_START), 1'b0);
    step_action(ACT_XCHG, 8'hfe, 8'h00);
    step_action(ACT_XCHG, 8'h01, 8'h00);
    // exchange while waiting for write data is dropped
    send_request(item_of(ACT_XCHG), 1'b0);
    step_action(ACT_WDATA, 8'h00, 8'h00);
    step_action(ACT_XCHG, 8'h00, 8'h00);
    step_action(ACT_WDATA, 8'hff, 8'hff);
    step_action(ACT_XCHG, 8'hff, 8'hff);
    pause_until_drained();

    // random part in four idling phases; the last transfer of a phase runs over
    for (ph = 0; ph < 4; ph++) begin
      idle_pct = idle_plan[ph];
      stall_pct = stall_plan[ph];
      base = item_count;
      while (item_count < base + 120) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          run_transfer(16'($urandom), 16'h0000, 1'($urandom), -1);
        end else if (pick < 12) begin
          // wait state runs out; any length, the first frame never ends
          run_transfer(16'($urandom), 16'($urandom), 1'($urandom), RETRY_LIMIT);
        end else begin
          pick = $urandom_range(99);
          if (pick < 60) len = 16'($urandom_range(8, 1));
          else if (pick < 85) len = 16'($urandom_range(70, 9));
          else len = 16'($urandom_range(200, 71));
          pick = $urandom_range(99);
          if (pick < 65) polls = -1;
          else if (pick < 90) polls = $urandom_range(3);
          else if (pick < 97) polls = $urandom_range(RETRY_LIMIT - 2, 4);
          else polls = RETRY_LIMIT - 1;
          run_transfer(16'($urandom), len, 1'($urandom), polls);
        end
        if ($urandom_range(99) < 3) pause_until_drained();
      end
      pause_until_drained();
    end

    // wait on so that nothing stray turns up before the verdict
    repeat (16) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
